/* sv/effective_gamma_force_factor_defines.svh */
// assertion macros for the effective gamma force factor block
`ifndef EFFECTIVE_GAMMA_FORCE_FACTOR_DEFINES_SVH
`define EFFECTIVE_GAMMA_FORCE_FACTOR_DEFINES_SVH

// plain clocked check, held off during reset
`define EGFF_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("egff: check failed");

// same-cycle implication
`define EGFF_ASSERT_IMP(lbl, ante, cons) `EGFF_ASSERT(lbl, (ante) |-> (cons))

`endif

/* sv/egff_pkg.sv */
// package of types and constants for the effective gamma force factor block
package egff_pkg;

    localparam int WordW     = 32;
    localparam int LogW      = 25;
    localparam int FracW     = 16;
    localparam int LogStages = 16;
    localparam int DivStages = 40;
    localparam int QuotW     = 41;
    localparam int FfW       = 16;
    localparam int CfgIdxW   = 8;
    localparam int CfgDataW  = 8;

    localparam logic [CfgIdxW-1:0] RegEnable = 8'd0;
    localparam logic [CfgIdxW-1:0] RegDepth  = 8'd1;

    localparam logic [16:0] GammaCap = 17'd87381;
    localparam logic [16:0] GammaLow = 17'd54395;
    localparam logic [16:0] OneQ16   = 17'd65536;
    localparam logic [15:0] FfMax    = 16'd62259;

    localparam logic [33:0] LoC0 = 34'd2576980378;
    localparam logic [17:0] LoC1 = 18'd163840;
    localparam logic [18:0] LoC2 = 19'd393216;
    localparam logic [33:0] HiC0 = 34'd4294967296;
    localparam logic [17:0] HiC1 = 18'd13107;
    localparam logic [18:0] HiC2 = 19'd190054;

    typedef struct packed {
        logic signed [QuotW-1:0] quot;
        logic                    zero;
    } t_div_res;

endpackage

/* sv/egff_if.sv */
// channel interfaces: cell input, result output and register writes
interface egff_in_if;
    logic                           valid;
    logic                           ready;
    logic [egff_pkg::WordW-1:0]     pressure_now;
    logic [egff_pkg::WordW-1:0]     pressure_prev;
    logic [egff_pkg::WordW-1:0]     pressure_prev2;
    logic [egff_pkg::WordW-1:0]     density_now;
    logic [egff_pkg::WordW-1:0]     density_prev;
    logic [egff_pkg::WordW-1:0]     density_prev2;
    modport source (output valid, pressure_now, pressure_prev, pressure_prev2,
                    density_now, density_prev, density_prev2, input ready);
    modport sink (input valid, pressure_now, pressure_prev, pressure_prev2,
                  density_now, density_prev, density_prev2, output ready);
endinterface

interface egff_out_if;
    logic                         valid;
    logic                         ready;
    logic [egff_pkg::FfW-1:0]     ff_q16;
    logic                         divide_fault;
    modport source (output valid, ff_q16, divide_fault, input ready);
    modport sink (input valid, ff_q16, divide_fault, output ready);
endinterface

interface egff_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [egff_pkg::CfgIdxW-1:0]    index;
    logic [egff_pkg::CfgDataW-1:0]   data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* sv/egff_log2.sv */
// pipelined base-2 logarithm of a binary32 magnitude, one squaring per stage
module egff_log2 (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic [egff_pkg::WordW-1:0]         i_word,
    output logic signed [egff_pkg::LogW-1:0]   o_log
);

    localparam int NS = egff_pkg::LogStages;

    logic [23:0]             r_y [NS];
    logic [NS-1:0]           r_f [NS];
    logic [7:0]              r_e [NS];
    logic [23:0]             n_y [NS];
    logic [NS-1:0]           n_f [NS];
    logic [7:0]              n_e [NS];
    logic [7:0]              dec_e;

    always_comb begin
        dec_e = i_word[30:23];
        if (dec_e == 8'd0) begin
            dec_e = 8'd1;
        end else if (dec_e == 8'hff) begin
            dec_e = 8'hfe;
        end
    end

    for (genvar s = 0; s < NS; s++) begin : g_stage
        logic [23:0]   y_in;
        logic [NS-1:0] f_in;
        logic [7:0]    e_in;
        logic [47:0]   sq;
        if (s == 0) begin : g_first
            assign y_in = {1'b1, i_word[22:0]};
            assign f_in = '0;
            assign e_in = dec_e;
        end else begin : g_next
            assign y_in = r_y[s-1];
            assign f_in = r_f[s-1];
            assign e_in = r_e[s-1];
        end
        always_comb begin
            sq = y_in * y_in;
            // product is Q2.46; back to Q.23, renormalise when it reached two
            if (sq[47]) begin
                n_y[s] = sq[47:24];
                n_f[s] = {f_in[NS-2:0], 1'b1};
            end else begin
                n_y[s] = sq[46:23];
                n_f[s] = {f_in[NS-2:0], 1'b0};
            end
            n_e[s] = e_in;
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_y[s] <= n_y[s];
                r_f[s] <= n_f[s];
                r_e[s] <= n_e[s];
            end
        end
    end

    assign o_log = $signed({9'({1'b0, r_e[NS-1]}) - 9'd127, r_f[NS-1]});

endmodule

/* sv/egff_div.sv */
// pipelined signed divide of (dp << 16) by dd, one quotient bit per stage
module egff_div (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic signed [egff_pkg::LogW-1:0]   i_dp,
    input  logic signed [egff_pkg::LogW-1:0]   i_dd,
    output egff_pkg::t_div_res                 o_res
);

    localparam int NS = egff_pkg::DivStages;
    localparam int MW = egff_pkg::LogW - 1;

    logic [MW-1:0] r_r [NS];
    logic [NS-1:0] r_q [NS];
    logic [MW-1:0] r_d [NS];
    logic          r_neg [NS];
    logic          r_zero [NS];
    logic [MW-1:0] mag_p;
    logic [MW-1:0] mag_d;

    assign mag_p = i_dp[MW] ? MW'(-i_dp) : MW'(i_dp);
    assign mag_d = i_dd[MW] ? MW'(-i_dd) : MW'(i_dd);

    for (genvar s = 0; s < NS; s++) begin : g_stage
        logic [MW-1:0] r_in;
        logic [NS-1:0] q_in;
        logic [MW-1:0] d_in;
        logic          neg_in;
        logic          zero_in;
        logic [MW:0]   trial;
        if (s == 0) begin : g_first
            assign r_in    = '0;
            assign q_in    = {mag_p, 16'd0};
            assign d_in    = mag_d;
            assign neg_in  = i_dp[MW] ^ i_dd[MW];
            assign zero_in = (i_dd == '0);
        end else begin : g_next
            assign r_in    = r_r[s-1];
            assign q_in    = r_q[s-1];
            assign d_in    = r_d[s-1];
            assign neg_in  = r_neg[s-1];
            assign zero_in = r_zero[s-1];
        end
        assign trial = {r_in, q_in[NS-1]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (trial >= {1'b0, d_in}) begin
                    r_r[s] <= MW'(trial - {1'b0, d_in});
                    r_q[s] <= {q_in[NS-2:0], 1'b1};
                end else begin
                    r_r[s] <= trial[MW-1:0];
                    r_q[s] <= {q_in[NS-2:0], 1'b0};
                end
                r_d[s]    <= d_in;
                r_neg[s]  <= neg_in;
                r_zero[s] <= zero_in;
            end
        end
    end

    // magnitude quotient, sign applied gives truncation toward zero
    assign o_res.quot = r_neg[NS-1] ? -$signed({1'b0, r_q[NS-1]})
                                    : $signed({1'b0, r_q[NS-1]});
    assign o_res.zero = r_zero[NS-1];

endmodule

/* sv/effective_gamma_force_factor.sv */
// top level of the effective gamma force factor pipeline
//
// one cell per clock; from input transfer to result it passes 16 stages of
// log2 (one significand squaring per stage, six lanes), one stage of log differences,
// 40 stages of restoring division (one quotient bit per stage, two lanes), then slope
// averaging and capping, two multiply stages for the quadratic and the output register.
// the whole pipeline advances whenever the output register is empty or its result is
// taken, so a held result stalls every stage together and nothing is lost or repeated.
// registers are written through the configuration channel, which is always ready; they
// are read at the slope stage and should only change while the pipeline is empty.
`include "effective_gamma_force_factor_defines.svh"

module effective_gamma_force_factor (
    input  logic       i_clk,
    input  logic       i_rst_n,
    egff_cfg_if.sink   i_cfg,
    egff_in_if.sink    i_in,
    egff_out_if.source o_out
);

    localparam int LS   = egff_pkg::LogStages;
    localparam int DS   = egff_pkg::DivStages;
    localparam int NSTG = LS + DS + 5;
    localparam int SG   = LS + DS + 1;   // slope stage index
    localparam int LW   = egff_pkg::LogW;

    logic            adv;
    logic [NSTG-1:0] r_vld;
    logic            r_enable;
    logic [1:0]      r_depth;

    // configuration registers
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_depth  <= 2'd0;
        end else if (i_cfg.valid) begin
            if (i_cfg.index == egff_pkg::RegEnable) begin
                r_enable <= i_cfg.data[0];
            end else if (i_cfg.index == egff_pkg::RegDepth) begin
                r_depth <= i_cfg.data[1:0];
            end
        end
    end

    // global advance: output empty or being taken
    assign adv        = !r_vld[NSTG-1] || o_out.ready;
    assign i_in.ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[NSTG-2:0], i_in.valid};
        end
    end

    // six log2 lanes
    logic signed [LW-1:0] lg_p0, lg_p1, lg_p2, lg_d0, lg_d1, lg_d2;

    egff_log2 u_log_p0 (.i_clk, .i_en(adv), .i_word(i_in.pressure_now),   .o_log(lg_p0));
    egff_log2 u_log_p1 (.i_clk, .i_en(adv), .i_word(i_in.pressure_prev),  .o_log(lg_p1));
    egff_log2 u_log_p2 (.i_clk, .i_en(adv), .i_word(i_in.pressure_prev2), .o_log(lg_p2));
    egff_log2 u_log_d0 (.i_clk, .i_en(adv), .i_word(i_in.density_now),    .o_log(lg_d0));
    egff_log2 u_log_d1 (.i_clk, .i_en(adv), .i_word(i_in.density_prev),   .o_log(lg_d1));
    egff_log2 u_log_d2 (.i_clk, .i_en(adv), .i_word(i_in.density_prev2),  .o_log(lg_d2));

    // log differences; magnitudes stay below 2^24 so no growth is needed
    logic signed [LW-1:0] r_dp1, r_dd1, r_dp2, r_dd2;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dp1 <= lg_p0 - lg_p1;
            r_dd1 <= lg_d0 - lg_d1;
            r_dp2 <= lg_p1 - lg_p2;
            r_dd2 <= lg_d1 - lg_d2;
        end
    end

    // recent and earlier slope
    egff_pkg::t_div_res sl1, sl2;
    egff_div u_div_1 (.i_clk, .i_en(adv), .i_dp(r_dp1), .i_dd(r_dd1), .o_res(sl1));
    egff_div u_div_2 (.i_clk, .i_en(adv), .i_dp(r_dp2), .i_dd(r_dd2), .o_res(sl2));

    // slope stage: mean, cap, branch choice
    logic signed [41:0] sum2;
    logic signed [41:0] half;
    logic signed [41:0] gv;
    logic               use2;
    logic               zero;
    logic               kill;
    logic signed [41:0] gcap;
    logic               r_fault_a, r_hi_a, r_none_a;
    logic signed [15:0] r_t;

    always_comb begin
        use2 = r_depth[1];
        sum2 = 42'(sl1.quot) + 42'(sl2.quot);
        // halve with truncation toward zero
        half = (sum2 + $signed(42'(sum2[41]))) >>> 1;
        gv   = use2 ? half : 42'(sl1.quot);
        zero = sl1.zero || (use2 && sl2.zero);
        kill = !r_enable || (r_depth == 2'd0);
        if (zero || gv > $signed({25'd0, egff_pkg::GammaCap})) begin
            gcap = $signed({25'd0, egff_pkg::GammaCap});
        end else begin
            gcap = gv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_fault_a <= zero && !kill;
            r_none_a  <= kill || (gcap < $signed({25'd0, egff_pkg::GammaLow}));
            r_hi_a    <= gcap >= $signed({25'd0, egff_pkg::OneQ16});
            if (gcap >= $signed({25'd0, egff_pkg::OneQ16})) begin
                r_t <= 16'(gcap - $signed({25'd0, egff_pkg::GammaCap}));
            end else begin
                r_t <= 16'(gcap - $signed({25'd0, egff_pkg::OneQ16}));
            end
        end
    end

    // first multiply stage: t squared and the linear term
    logic signed [31:0] tt;
    logic signed [35:0] c1t;
    logic [28:0]        r_tt;
    logic signed [35:0] r_lin;
    logic               r_hi_b, r_none_b, r_fault_b;

    always_comb begin
        tt  = r_t * r_t;
        c1t = $signed({1'b0, (r_hi_a ? egff_pkg::HiC1 : egff_pkg::LoC1)}) * r_t;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_tt      <= tt[28:0];
            r_lin     <= $signed({2'b00, (r_hi_a ? egff_pkg::HiC0 : egff_pkg::LoC0)}) + c1t;
            r_hi_b    <= r_hi_a;
            r_none_b  <= r_none_a;
            r_fault_b <= r_fault_a;
        end
    end

    // second multiply stage: quadratic term
    logic [47:0]        c2tt;
    logic [31:0]        r_sq;
    logic signed [35:0] r_lin_c;
    logic               r_none_c, r_fault_c;

    assign c2tt = (r_hi_b ? egff_pkg::HiC2 : egff_pkg::LoC2) * r_tt;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sq      <= c2tt[47:16];
            r_lin_c   <= r_lin;
            r_none_c  <= r_none_b;
            r_fault_c <= r_fault_b;
        end
    end

    // output register: round to q16 and clamp
    logic signed [36:0] v;
    logic [36:0]        rnd;
    logic [15:0]        n_ff;
    logic [15:0]        r_ff;
    logic               r_fault;

    always_comb begin
        v   = 37'(r_lin_c) - $signed({5'd0, r_sq});
        rnd = (37'(v) + 37'd32768) >> 16;
        if (r_none_c || v <= 0) begin
            n_ff = '0;
        end else if (rnd > 37'(egff_pkg::FfMax)) begin
            n_ff = egff_pkg::FfMax;
        end else begin
            n_ff = rnd[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ff    <= n_ff;
            r_fault <= r_fault_c;
        end
    end

    assign o_out.valid        = r_vld[NSTG-1];
    assign o_out.ff_q16       = r_ff;
    assign o_out.divide_fault = r_fault;

    // a fault pins gamma at the cap, which always lands on the clamp value
    `EGFF_ASSERT_IMP(a_fault_clamped, o_out.valid && o_out.divide_fault,
        o_out.ff_q16 == egff_pkg::FfMax)
    `EGFF_ASSERT_IMP(a_ff_range, o_out.valid, o_out.ff_q16 <= egff_pkg::FfMax)
    // a fault at the slope stage never takes the zero branch
    `EGFF_ASSERT_IMP(a_fault_live, r_vld[SG] && r_fault_a, !r_none_a)
    // a held result stays put until it is taken
    `EGFF_ASSERT(a_out_hold,
        o_out.valid && !o_out.ready |=> o_out.valid && $stable(o_out.ff_q16))

endmodule
